/* rtl/ssp_pkg.sv */
// Shared constants and types for the servo short packet framer.
package ssp_pkg;

	// Largest number of data bytes a packet carries (range 1 to 8)
	localparam int MAX_DATA_BYTES = 4;

	localparam int DATA_W   = MAX_DATA_BYTES * 8;
	localparam int LEN_W    = $clog2(MAX_DATA_BYTES + 1);
	localparam int DSEL_W   = (MAX_DATA_BYTES > 1) ? $clog2(MAX_DATA_BYTES) : 1;
	localparam int PKT_MAX  = 8 + MAX_DATA_BYTES;
	localparam int IDX_W    = $clog2(PKT_MAX);

	// Input word layout
	localparam int IN_W     = 67;
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;

	// Fixed packet bytes
	localparam logic [7:0] HDR_FIRST  = 8'hFA;
	localparam logic [7:0] HDR_SECOND = 8'hAF;

	// Byte positions in the packet
	localparam logic [IDX_W-1:0] POS_HDR_FIRST  = IDX_W'(0);
	localparam logic [IDX_W-1:0] POS_HDR_SECOND = IDX_W'(1);
	localparam logic [IDX_W-1:0] POS_ID         = IDX_W'(2);
	localparam logic [IDX_W-1:0] POS_FLAGS      = IDX_W'(3);
	localparam logic [IDX_W-1:0] POS_ADDR       = IDX_W'(4);
	localparam logic [IDX_W-1:0] POS_LEN        = IDX_W'(5);
	localparam logic [IDX_W-1:0] POS_COUNT      = IDX_W'(6);
	localparam logic [IDX_W-1:0] POS_DATA       = IDX_W'(7);

	typedef enum logic {
		ST_IDLE,
		ST_SEND
	} seq_state_t;

	// Sequencer commands to the byte unit
	typedef struct packed {
		logic             load;
		logic             step;
		logic [IDX_W-1:0] idx;
	} byte_ctrl_t;

endpackage

/* rtl/ssp_byte_unit.sv */
// Command holding registers, packet byte selector and XOR checksum accumulator.
module ssp_byte_unit import ssp_pkg::*; (
	input  logic             clk,
	input  logic [IN_W-1:0]  cmd,
	input  byte_ctrl_t       ctrl,
	output logic [IDX_W-1:0] last_idx,
	output logic [7:0]       pkt_byte,
	output logic             pkt_last
);

	logic [7:0]        id_q;
	logic [7:0]        flags_q;
	logic [7:0]        addr_q;
	logic [LEN_W-1:0]  len_q;
	logic [7:0]        count_q;
	logic [DATA_W-1:0] payload_q;
	logic [7:0]        sum_q;

	logic [LEN_W:0]    raw_len;
	logic [LEN_W-1:0]  clamped_len;
	logic [IDX_W-1:0]  data_off;
	logic [DSEL_W-1:0] data_sel;
	logic [7:0]        data_byte;
	logic              in_sum;

	// Saturate the requested length at the data limit
	always_comb begin
		raw_len = (LEN_W + 1)'(cmd[26:24]);
		if (raw_len > (LEN_W + 1)'(MAX_DATA_BYTES)) begin
			clamped_len = LEN_W'(MAX_DATA_BYTES);
		end else begin
			clamped_len = raw_len[LEN_W-1:0];
		end
	end

	// Capture the command fields on load
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			id_q      <= cmd[7:0];
			flags_q   <= cmd[15:8];
			addr_q    <= cmd[23:16];
			len_q     <= clamped_len;
			count_q   <= cmd[34:27];
			payload_q <= DATA_W'({{DATA_W{1'b0}}, cmd[66:35]});
		end
	end

	assign last_idx  = POS_DATA + IDX_W'(len_q);
	assign data_off  = ctrl.idx - POS_DATA;
	assign data_sel  = data_off[DSEL_W-1:0];
	assign data_byte = payload_q[{data_sel, 3'b000} +: 8];

	// Pick the byte for the current packet position
	always_comb begin
		pkt_last = 1'b0;
		in_sum   = 1'b1;
		priority if (ctrl.idx == POS_HDR_FIRST) begin
			pkt_byte = HDR_FIRST;
			in_sum   = 1'b0;
		end else if (ctrl.idx == POS_HDR_SECOND) begin
			pkt_byte = HDR_SECOND;
			in_sum   = 1'b0;
		end else if (ctrl.idx == POS_ID) begin
			pkt_byte = id_q;
		end else if (ctrl.idx == POS_FLAGS) begin
			pkt_byte = flags_q;
		end else if (ctrl.idx == POS_ADDR) begin
			pkt_byte = addr_q;
		end else if (ctrl.idx == POS_LEN) begin
			pkt_byte = 8'(len_q);
		end else if (ctrl.idx == POS_COUNT) begin
			pkt_byte = count_q;
		end else if (ctrl.idx == last_idx) begin
			pkt_byte = sum_q;
			pkt_last = 1'b1;
			in_sum   = 1'b0;
		end else begin
			pkt_byte = data_byte;
		end
	end

	// Clear on load, fold each covered byte in as it is sent
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			sum_q <= 8'h00;
		end else if (ctrl.step && in_sum) begin
			sum_q <= sum_q ^ pkt_byte;
		end
	end

endmodule

/* rtl/ssp_seq.sv */
// Packet sequencer: walks the byte positions of one packet.
module ssp_seq import ssp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cmd_valid,
	input  logic             out_free,
	input  logic [IDX_W-1:0] last_idx,
	output logic             cmd_ready,
	output byte_ctrl_t       ctrl
);

	seq_state_t       state_q;
	seq_state_t       state_d;
	logic [IDX_W-1:0] idx_q;
	logic             at_end;

	assign at_end = (idx_q == last_idx);

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd_valid) begin
					state_d = ST_SEND;
				end
			end
			ST_SEND: begin
				if (out_free && at_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Outputs
	always_comb begin
		cmd_ready = 1'b0;
		ctrl.load = 1'b0;
		ctrl.step = 1'b0;
		ctrl.idx  = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd_ready = 1'b1;
				ctrl.load = cmd_valid;
			end
			ST_SEND: begin
				ctrl.step = out_free;
			end
			default: begin
				cmd_ready = 1'b0;
			end
		endcase
	end

	// Hold state, advance the byte position on each step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctrl.load) begin
				idx_q <= '0;
			end else if (ctrl.step) begin
				idx_q <= idx_q + IDX_W'(1);
			end
		end
	end

endmodule

/* rtl/servo_short_packet_framer_unit.sv */
// Top level of the servo short packet framer.
//
// Usage: one command transfer on the s_ channel produces one short packet on
// the m_ channel, one byte per transfer: 0xFA, 0xAF, id, flags, address,
// length, count, the data bytes least significant first, then the XOR
// checksum of id through the last data byte, marked by m_tlast.
// A length above the data limit is sent as the limit.
// After a command transfer the sequencer enters its send state, and the
// bytes are then loaded into the output register one per cycle while
// m_tready allows, one byte position per step through the shared byte
// select and XOR unit; a packet of N data bytes has 8 + N positions.
// s_tready is high only while the sequencer is idle, so a new command is
// accepted in the cycle after the checksum byte is loaded.
// Reset (arst_n low) returns the sequencer to idle and empties the output
// register; the block holds no state between commands.
// Stall: while m_tready is low the output register holds its byte and the
// sequencer waits on the current position; nothing is lost or repeated.
module servo_short_packet_framer_unit import ssp_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	// fields from bit 0: servo_id[7:0], flag_bits[15:8], mem_address[23:16],
	// data_len[26:24], servo_count[34:27], payload[66:35], zero pad
	input  logic [IN_TDATA_W-1:0] s_tdata,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	// fields from bit 0: tx_byte[7:0]
	output logic [7:0]            m_tdata,
	output logic                  m_tlast
);

	byte_ctrl_t       ctrl;
	logic [IDX_W-1:0] last_idx;
	logic [7:0]       pkt_byte;
	logic             pkt_last;
	logic             out_free;
	logic             m_tvalid_q;
	logic [7:0]       m_tdata_q;
	logic             m_tlast_q;

	assign out_free = !m_tvalid_q || m_tready;

	ssp_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (s_tvalid),
		.out_free  (out_free),
		.last_idx  (last_idx),
		.cmd_ready (s_tready),
		.ctrl      (ctrl)
	);

	ssp_byte_unit u_byte (
		.clk      (clk),
		.cmd      (s_tdata[IN_W-1:0]),
		.ctrl     (ctrl),
		.last_idx (last_idx),
		.pkt_byte (pkt_byte),
		.pkt_last (pkt_last)
	);

	// Output register: load on each step, drop valid once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.step) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			m_tdata_q <= pkt_byte;
			m_tlast_q <= pkt_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	// Idle with a byte pending means only the checksum is left
	a_idle_pending_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && m_tvalid) |-> m_tlast)
		else $error("idle with a non-final byte pending");

	// A command transfer starts a packet, so the input side closes
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("input still open after command transfer");

	// Idle at the final byte transfer with no command offered: stay idle
	a_idle_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tready && !s_tvalid && m_tvalid && m_tready && m_tlast) |=> s_tready)
		else $error("not idle after packet end");

	// The first byte loaded after a command is the first header byte
	a_header_first: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> (ctrl.idx == POS_HDR_FIRST))
		else $error("packet does not start at the first header byte");

endmodule
